// File: sv/qpsd_pkg.sv
package qpsd_pkg;

  // field and datapath widths
  localparam int POS_W  = 16;
  localparam int TIME_W = 48;
  localparam int APC_W  = 32;
  localparam int SPD_W  = 32;
  localparam int DIR_W  = 2;
  localparam int LEV_W  = 2;
  localparam int QCNT_W = 3;
  localparam int KIND_W = 2;

  // speed numerator is angle_per_count times one million
  localparam int             US_W       = 20;
  localparam logic [US_W-1:0] US_PER_SEC = US_W'(1000000);
  localparam int             NUM_W      = APC_W + US_W;

  // modulo unit covers position plus or minus one and the modulus itself
  localparam int MOD_W      = POS_W + 1;
  localparam int DIV_STEPS  = SPD_W;
  localparam int MOD_STEPS  = MOD_W;
  localparam int STEP_CNT_W = $clog2(DIV_STEPS);

  localparam logic [QCNT_W-1:0] QUARTERS = QCNT_W'(4);

  // saturation limits of the signed speed
  localparam logic [SPD_W-1:0] SPD_POS_MAX = {1'b0, {(SPD_W-1){1'b1}}};
  localparam logic [SPD_W-1:0] SPD_NEG_MAX = {1'b1, {(SPD_W-1){1'b0}}};

  // direction codes
  localparam logic [DIR_W-1:0] DIR_STILL = 2'd0;
  localparam logic [DIR_W-1:0] DIR_CW    = 2'd1;
  localparam logic [DIR_W-1:0] DIR_ACW   = 2'd2;

  // request actions
  localparam logic ACT_LEVEL = 1'b0;
  localparam logic ACT_ZERO  = 1'b1;

  // work kinds handed from front to back
  localparam logic [KIND_W-1:0] KIND_HOLD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ZERO = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STEP = 2'd2;

  // register map, index is paddr[3:2]
  localparam int               ADDR_W    = 4;
  localparam int               REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_CPR   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_APC   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PHASE = 2'd2;
  localparam int               DATA_W    = 32;

  localparam logic [POS_W-1:0] CPR_RST   = POS_W'(1024);
  localparam logic [APC_W-1:0] APC_RST   = APC_W'(23040);
  localparam logic [LEV_W-1:0] PHASE_RST = 2'd0;

  // queue depth between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DIR_W-1:0]  dir;
    logic [TIME_W-1:0] period;
  } qentry_t;

  typedef struct packed {
    logic [POS_W-1:0] cpr;
    logic [APC_W-1:0] apc;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic [LEV_W-1:0] value;
  } phase_load_t;

  // clockwise gray order 00 -> 10 -> 11 -> 01 -> 00
  function automatic logic [LEV_W-1:0] next_cw(input logic [LEV_W-1:0] p);
    logic [LEV_W-1:0] n;
    case (p)
      2'd0:    n = 2'd2;
      2'd1:    n = 2'd0;
      2'd2:    n = 2'd3;
      2'd3:    n = 2'd1;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic [LEV_W-1:0] next_acw(input logic [LEV_W-1:0] p);
    logic [LEV_W-1:0] n;
    case (p)
      2'd0:    n = 2'd1;
      2'd1:    n = 2'd3;
      2'd2:    n = 2'd0;
      2'd3:    n = 2'd2;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

// File: sv/quadrature_position_speed_decoder_unit.sv
// x1 quadrature decoder with wrapping position, angle and signed speed in Q16.16 per second.
// Each request gives exactly one result showing the state after it. The front end decodes
// the gray step in the cycle a request is taken and passes it through a two-entry queue, so
// requests are accepted at one per cycle until the queue fills. The back end passes a repeated,
// illegal, quarter-step or zero request from idle straight to done, and a request that completes
// a full cycle through the prep, load, divide, angle and finish states, where the 32-step radix-2
// speed divider runs in parallel with the 17-step position modulo. A result waits in the output
// register without blocking the next request. There is no clearing pass after reset.
module quadrature_position_speed_decoder_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_action,
  input  logic [qpsd_pkg::LEV_W-1:0]         in_ab_levels,
  input  logic [qpsd_pkg::TIME_W-1:0]        in_time_us,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [qpsd_pkg::DIR_W-1:0]         out_direction,
  output logic [qpsd_pkg::POS_W-1:0]         out_position,
  output logic [qpsd_pkg::APC_W-1:0]         out_angle,
  output logic signed [qpsd_pkg::SPD_W-1:0]  out_speed,
  output logic                               out_step_done,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [qpsd_pkg::ADDR_W-1:0]        paddr,
  input  logic [qpsd_pkg::DATA_W-1:0]        pwdata,
  output logic [qpsd_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);
  import qpsd_pkg::*;

  logic [POS_W-1:0]     cpr_r;
  logic [APC_W-1:0]     apc_r;
  logic [LEV_W-1:0]     sphase_r;
  logic                 cfg_write;
  logic [REG_IDX_W-1:0] reg_idx;
  cfg_t                 cfg;
  phase_load_t          phase_load;
  qentry_t              push_entry;
  qentry_t              pop_entry;
  logic                 push;
  logic                 pop;
  logic                 q_full;
  logic                 q_empty;

  // register port
  assign pready          = 1'b1;
  assign reg_idx         = paddr[ADDR_W-1:2];
  assign cfg_write       = psel & penable & pwrite & pready;
  assign phase_load.load = cfg_write && (reg_idx == REG_PHASE);
  assign phase_load.value = pwdata[LEV_W-1:0];
  assign cfg.cpr         = cpr_r;
  assign cfg.apc         = apc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r    <= CPR_RST;
      apc_r    <= APC_RST;
      sphase_r <= PHASE_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_CPR:   cpr_r    <= pwdata[POS_W-1:0];
        REG_APC:   apc_r    <= pwdata[APC_W-1:0];
        REG_PHASE: sphase_r <= pwdata[LEV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_CPR:   prdata = DATA_W'(cpr_r);
      REG_APC:   prdata = DATA_W'(apc_r);
      REG_PHASE: prdata = DATA_W'(sphase_r);
      default:   prdata = '0;
    endcase
  end

  qpsd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_ab_levels (in_ab_levels),
    .in_time_us   (in_time_us),
    .phase_load   (phase_load),
    .q_full       (q_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  qpsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  qpsd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .empty         (q_empty),
    .pop_entry     (pop_entry),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_direction (out_direction),
    .out_position  (out_position),
    .out_angle     (out_angle),
    .out_speed     (out_speed),
    .out_step_done (out_step_done)
  );

endmodule

// File: sv/qpsd_front.sv
module qpsd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [qpsd_pkg::LEV_W-1:0]    in_ab_levels,
  input  logic [qpsd_pkg::TIME_W-1:0]   in_time_us,
  input  qpsd_pkg::phase_load_t         phase_load,
  input  logic                          q_full,
  output logic                          push,
  output qpsd_pkg::qentry_t             push_entry
);
  import qpsd_pkg::*;

  logic [LEV_W-1:0]  phase_r, phase_nxt;
  logic [DIR_W-1:0]  dir_r, dir_nxt;
  logic [QCNT_W-1:0] qcnt_r, qcnt_nxt;
  logic [TIME_W-1:0] mark_r, mark_nxt;
  logic [QCNT_W-1:0] qcnt_tmp;
  logic [DIR_W-1:0]  step_dir;
  logic              accept;
  logic              cw_hit;
  logic              acw_hit;

  // requests enter whenever the queue has room
  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;
  assign push     = accept;
  assign cw_hit   = (in_ab_levels == next_cw(phase_r));
  assign acw_hit  = (in_ab_levels == next_acw(phase_r));

  // gray decode, quarter counting and period measurement
  always_comb begin
    phase_nxt         = phase_r;
    dir_nxt           = dir_r;
    qcnt_nxt          = qcnt_r;
    mark_nxt          = mark_r;
    qcnt_tmp          = qcnt_r;
    step_dir          = cw_hit ? DIR_CW : DIR_ACW;
    push_entry.kind   = KIND_HOLD;
    push_entry.period = in_time_us - mark_r;
    if (accept) begin
      if (in_action == ACT_ZERO) begin
        dir_nxt         = DIR_STILL;
        push_entry.kind = KIND_ZERO;
      end else if (cw_hit || acw_hit) begin
        phase_nxt = in_ab_levels;
        dir_nxt   = step_dir;
        if (dir_r == DIR_STILL) begin
          mark_nxt = in_time_us;
          qcnt_tmp = '0;
        end else if (dir_r != step_dir) begin
          qcnt_tmp = '0;
        end
        qcnt_tmp = qcnt_tmp + QCNT_W'(1);
        // fourth quarter in one direction completes a full cycle
        if (qcnt_tmp >= QUARTERS) begin
          qcnt_tmp        = '0;
          mark_nxt        = in_time_us;
          push_entry.kind = KIND_STEP;
        end
        qcnt_nxt = qcnt_tmp;
      end
    end
    if (phase_load.load) begin
      phase_nxt = phase_load.value;
    end
    push_entry.dir = dir_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_RST;
      dir_r   <= DIR_STILL;
      qcnt_r  <= '0;
      mark_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      dir_r   <= dir_nxt;
      qcnt_r  <= qcnt_nxt;
      mark_r  <= mark_nxt;
    end
  end

endmodule

// File: sv/qpsd_queue.sv
module qpsd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  qpsd_pkg::qentry_t push_entry,
  output logic              full,
  input  logic              pop,
  output qpsd_pkg::qentry_t pop_entry,
  output logic              empty
);
  import qpsd_pkg::*;

  qentry_t             entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;

  assign full      = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty     = (cnt_r == '0);
  assign pop_entry = entry_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: sv/qpsd_back.sv
module qpsd_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  qpsd_pkg::cfg_t                     cfg,
  input  logic                               empty,
  input  qpsd_pkg::qentry_t                  pop_entry,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [qpsd_pkg::DIR_W-1:0]         out_direction,
  output logic [qpsd_pkg::POS_W-1:0]         out_position,
  output logic [qpsd_pkg::APC_W-1:0]         out_angle,
  output logic signed [qpsd_pkg::SPD_W-1:0]  out_speed,
  output logic                               out_step_done
);
  import qpsd_pkg::*;

  localparam int                 STATE_W  = 3;
  localparam logic [STATE_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [STATE_W-1:0] ST_PREP  = 3'd1;
  localparam logic [STATE_W-1:0] ST_LOAD  = 3'd2;
  localparam logic [STATE_W-1:0] ST_DIV   = 3'd3;
  localparam logic [STATE_W-1:0] ST_ANG   = 3'd4;
  localparam logic [STATE_W-1:0] ST_FIN   = 3'd5;
  localparam logic [STATE_W-1:0] ST_DONE  = 3'd6;
  localparam int                 PROD_W   = POS_W + APC_W;
  localparam int                 HI_W     = NUM_W - SPD_W;

  logic [STATE_W-1:0]    state_r, state_nxt;
  logic [DIR_W-1:0]      dir_r, dir_nxt;
  logic                  step_r, step_nxt;
  logic [TIME_W-1:0]     period_r, period_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [APC_W-1:0]      ang_r, ang_nxt;
  logic [SPD_W-1:0]      spd_r, spd_nxt;
  logic [NUM_W-1:0]      num_r, num_nxt;
  logic [TIME_W-1:0]     drem_r, drem_nxt;
  logic [SPD_W-1:0]      dquo_r, dquo_nxt;
  logic                  dsat_r, dsat_nxt;
  logic [MOD_W-1:0]      mrem_r, mrem_nxt;
  logic [MOD_W-1:0]      mval_r, mval_nxt;
  logic [MOD_W-1:0]      mdiv_r, mdiv_nxt;
  logic [STEP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic                  ovld_r, ovld_nxt;
  logic [DIR_W-1:0]      odir_r, odir_nxt;
  logic [POS_W-1:0]      opos_r, opos_nxt;
  logic [APC_W-1:0]      oang_r, oang_nxt;
  logic [SPD_W-1:0]      ospd_r, ospd_nxt;
  logic                  ostep_r, ostep_nxt;
  logic [MOD_W-1:0]      mod_m;
  logic [TIME_W:0]       dt;
  logic [MOD_W:0]        mt;
  logic [HI_W-1:0]       num_hi;
  logic                  out_free;

  assign out_valid     = ovld_r;
  assign out_direction = odir_r;
  assign out_position  = opos_r;
  assign out_angle     = oang_r;
  assign out_speed     = ospd_r;
  assign out_step_done = ostep_r;

  assign out_free = ~ovld_r | ~out_stall;
  assign num_hi   = num_r[NUM_W-1:SPD_W];
  // zero counts per revolution acts as the full position range
  assign mod_m    = (cfg.cpr == '0) ? {1'b1, {POS_W{1'b0}}} : {1'b0, cfg.cpr};
  // one restoring step each for the speed divider and the position modulo
  assign dt       = {drem_r, dquo_r[SPD_W-1]};
  assign mt       = {mrem_r, mval_r[MOD_W-1]};

  // sequencer for one queued request
  always_comb begin
    state_nxt  = state_r;
    dir_nxt    = dir_r;
    step_nxt   = step_r;
    period_nxt = period_r;
    pos_nxt    = pos_r;
    ang_nxt    = ang_r;
    spd_nxt    = spd_r;
    num_nxt    = num_r;
    drem_nxt   = drem_r;
    dquo_nxt   = dquo_r;
    dsat_nxt   = dsat_r;
    mrem_nxt   = mrem_r;
    mval_nxt   = mval_r;
    mdiv_nxt   = mdiv_r;
    cnt_nxt    = cnt_r;
    prod_nxt   = prod_r;
    ovld_nxt   = ovld_r & out_stall;
    odir_nxt   = odir_r;
    opos_nxt   = opos_r;
    oang_nxt   = oang_r;
    ospd_nxt   = ospd_r;
    ostep_nxt  = ostep_r;
    pop        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          dir_nxt    = pop_entry.dir;
          period_nxt = pop_entry.period;
          step_nxt   = 1'b0;
          state_nxt  = ST_DONE;
          if (pop_entry.kind == KIND_ZERO) begin
            pos_nxt = '0;
            ang_nxt = '0;
          end else if (pop_entry.kind == KIND_STEP) begin
            step_nxt  = 1'b1;
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        // speed numerator and the modulo operands
        num_nxt  = NUM_W'(cfg.apc) * NUM_W'(US_PER_SEC);
        mdiv_nxt = mod_m;
        mrem_nxt = '0;
        if (dir_r == DIR_CW) begin
          mval_nxt = {1'b0, pos_r} + MOD_W'(1);
        end else begin
          mval_nxt = {1'b0, pos_r} + mod_m - MOD_W'(1);
        end
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        // a quotient of 2^32 or more, or a zero period, saturates
        dsat_nxt  = (period_r == '0) || (TIME_W'(num_hi) >= period_r);
        drem_nxt  = TIME_W'(num_hi);
        dquo_nxt  = num_r[SPD_W-1:0];
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (dt >= {1'b0, period_r}) begin
          drem_nxt = TIME_W'(dt - {1'b0, period_r});
          dquo_nxt = {dquo_r[SPD_W-2:0], 1'b1};
        end else begin
          drem_nxt = dt[TIME_W-1:0];
          dquo_nxt = {dquo_r[SPD_W-2:0], 1'b0};
        end
        if (cnt_r < STEP_CNT_W'(MOD_STEPS)) begin
          mval_nxt = {mval_r[MOD_W-2:0], 1'b0};
          if (mt >= {1'b0, mdiv_r}) begin
            mrem_nxt = MOD_W'(mt - {1'b0, mdiv_r});
          end else begin
            mrem_nxt = mt[MOD_W-1:0];
          end
        end
        cnt_nxt = cnt_r + STEP_CNT_W'(1);
        if (cnt_r == STEP_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_ANG;
        end
      end
      ST_ANG: begin
        pos_nxt  = mrem_r[POS_W-1:0];
        prod_nxt = PROD_W'(mrem_r[POS_W-1:0]) * PROD_W'(cfg.apc);
        // signed saturation of the speed magnitude
        if (dir_r == DIR_ACW) begin
          spd_nxt = (dsat_r || dquo_r[SPD_W-1]) ? SPD_NEG_MAX : ~dquo_r + SPD_W'(1);
        end else begin
          spd_nxt = (dsat_r || dquo_r[SPD_W-1]) ? SPD_POS_MAX : dquo_r;
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        ang_nxt   = (|prod_r[PROD_W-1:APC_W]) ? '1 : prod_r[APC_W-1:0];
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          ovld_nxt  = 1'b1;
          odir_nxt  = dir_r;
          opos_nxt  = pos_r;
          oang_nxt  = ang_r;
          ospd_nxt  = spd_r;
          ostep_nxt = step_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ovld_r  <= 1'b0;
      pos_r   <= '0;
      ang_r   <= '0;
      spd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
      pos_r   <= pos_nxt;
      ang_r   <= ang_nxt;
      spd_r   <= spd_nxt;
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    dir_r    <= dir_nxt;
    step_r   <= step_nxt;
    period_r <= period_nxt;
    num_r    <= num_nxt;
    drem_r   <= drem_nxt;
    dquo_r   <= dquo_nxt;
    dsat_r   <= dsat_nxt;
    mrem_r   <= mrem_nxt;
    mval_r   <= mval_nxt;
    mdiv_r   <= mdiv_nxt;
    cnt_r    <= cnt_nxt;
    prod_r   <= prod_nxt;
    odir_r   <= odir_nxt;
    opos_r   <= opos_nxt;
    oang_r   <= oang_nxt;
    ospd_r   <= ospd_nxt;
    ostep_r  <= ostep_nxt;
  end

endmodule

// File: sv/qpsd_checker.sv
module qpsd_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [qpsd_pkg::DIR_W-1:0]         out_direction,
  input logic [qpsd_pkg::POS_W-1:0]         out_position,
  input logic [qpsd_pkg::APC_W-1:0]         out_angle,
  input logic signed [qpsd_pkg::SPD_W-1:0]  out_speed,
  input logic                               out_step_done
);
  import qpsd_pkg::*;

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_direction) &&
      $stable(out_position) && $stable(out_angle) && $stable(out_speed) &&
      $stable(out_step_done))
    else $error("stalled result changed");

  // a completed cycle always carries a direction
  a_step_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_step_done |-> out_direction == DIR_CW || out_direction == DIR_ACW)
    else $error("full step without direction");

  // speed sign follows the direction of the step that set it
  a_cw_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_step_done && out_direction == DIR_CW |-> !out_speed[SPD_W-1])
    else $error("clockwise step with negative speed");

  a_acw_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_step_done && out_direction == DIR_ACW |->
      out_speed[SPD_W-1] || out_speed == '0)
    else $error("anticlockwise step with positive speed");

endmodule

bind quadrature_position_speed_decoder_unit qpsd_checker u_qpsd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_direction (out_direction),
  .out_position  (out_position),
  .out_angle     (out_angle),
  .out_speed     (out_speed),
  .out_step_done (out_step_done)
);
